// File: hw/rtl/scf_pkg.sv
package scf_pkg;

	localparam int unsigned STRIP_W  = 10;
	localparam int unsigned SIGNAL_W = 16;
	localparam int unsigned MAG_W    = 15;
	localparam int unsigned NOISE_W  = 12;
	localparam int unsigned NSIG_W   = 4;
	localparam int unsigned THR_W    = 16;
	localparam int unsigned ENERGY_W = 25;
	localparam int unsigned WEIGHT_W = 35;
	localparam int unsigned PROD_W   = 25;
	localparam int unsigned SIZE_W   = 11;
	localparam int unsigned COG_W    = 18;
	localparam int unsigned COG_FRAC = 8;
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 56;

	localparam logic [NSIG_W-1:0] NSIGMA_RESET = 4'd6;

	// action codes of an input request
	localparam logic ACTION_SAMPLE = 1'b0;
	localparam logic ACTION_END    = 1'b1;

	typedef struct packed {
		logic capture;
		logic eval;
		logic start;
		logic accum;
		logic clear;
		logic div_load;
		logic div_step;
		logic rec_empty;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_end;
		logic hit;
		logic open;
		logic near;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

// File: hw/rtl/scf_div.sv
module scf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic                          step,
	input  logic [scf_pkg::WEIGHT_W-1:0]  weight,
	input  logic [scf_pkg::ENERGY_W-1:0]  energy,
	output logic [scf_pkg::COG_W-1:0]     quotient,
	output logic                          done
);
	import scf_pkg::*;

	localparam int unsigned CNT_W = $clog2(COG_W + 1);
	localparam int unsigned LOW_W = COG_W - COG_FRAC;

	logic [ENERGY_W-1:0] rem_q;
	logic [ENERGY_W-1:0] den_q;
	logic [COG_W-1:0]    dvd_q;
	logic [COG_W-1:0]    quo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                ovf;
	logic [ENERGY_W:0]   trial;
	logic                fits;

	// quotient of (weight * 256) / energy saturates once weight >= energy * 1024
	assign ovf   = weight >= {energy, LOW_W'(0)};
	assign trial = {rem_q, dvd_q[COG_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= ovf ? '0 : CNT_W'(COG_W);
		end else if (step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			den_q <= energy;
			rem_q <= weight[WEIGHT_W-1 -: ENERGY_W];
			dvd_q <= {weight[WEIGHT_W-ENERGY_W-1:0], COG_FRAC'(0)};
			quo_q <= ovf ? '1 : '0;
		end else if (step && cnt_q != '0) begin
			rem_q <= fits ? ENERGY_W'(trial - {1'b0, den_q}) : trial[ENERGY_W-1:0];
			dvd_q <= {dvd_q[COG_W-2:0], 1'b0};
			quo_q <= {quo_q[COG_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = cnt_q == '0;

endmodule

// File: hw/rtl/scf_dp.sv
module scf_dp #(
	parameter int unsigned STRIP_COUNT = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  scf_pkg::cmd_t                   cmd,
	output scf_pkg::sts_t                   sts,
	input  logic                            cfg_valid,
	input  logic [scf_pkg::NSIG_W-1:0]      cfg_data,
	input  logic [scf_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [scf_pkg::IN_USER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [scf_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                            m_tuser,
	output logic                            m_tlast
);
	import scf_pkg::*;

	logic [NSIG_W-1:0]   nsig_q;
	logic                act_q, good_q;
	logic [STRIP_W-1:0]  strip_q;
	logic [SIGNAL_W-1:0] sig_q;
	logic [NOISE_W-1:0]  noise_q;

	logic                hit_q, near_q;
	logic [MAG_W-1:0]    mag_q;
	logic [PROD_W-1:0]   prod_q;

	logic                open_q;
	logic [STRIP_W-1:0]  last_q;
	logic [ENERGY_W-1:0] esum_q;
	logic [WEIGHT_W-1:0] wsum_q;
	logic [SIZE_W-1:0]   size_q;

	logic [ENERGY_W-1:0] rec_e_q;
	logic [SIZE_W-1:0]   rec_n_q;
	logic                rec_valid_q, rec_last_q;

	logic                mvalid_q, mvalidbit_q, mlast_q;
	logic [OUT_DATA_W-1:0] mdata_q;

	logic [THR_W-1:0]    thr;
	logic                strip_ok, hit, near;
	logic [STRIP_W:0]    sa, sb;
	logic [ENERGY_W:0]   e_add;
	logic [WEIGHT_W:0]   w_add;
	logic [COG_W-1:0]    quo;
	logic                div_done;
	logic [COG_W-1:0]    cog;

	assign thr      = THR_W'(nsig_q) * THR_W'(noise_q);
	assign strip_ok = 32'(strip_q) < 32'(STRIP_COUNT);
	assign hit      = good_q && strip_ok &&
	                  ($signed({sig_q[SIGNAL_W-1], sig_q}) > $signed({1'b0, thr}));
	assign sa       = {1'b0, strip_q};
	assign sb       = {1'b0, last_q};
	assign near     = (sa == sb) || (sa == sb + 1'b1) || (sb == sa + 1'b1);
	assign e_add    = {1'b0, esum_q} + (ENERGY_W+1)'(mag_q);
	assign w_add    = {1'b0, wsum_q} + (WEIGHT_W+1)'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nsig_q <= NSIGMA_RESET;
		end else if (cfg_valid) begin
			nsig_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q   <= s_tuser[0];
			good_q  <= s_tuser[1];
			strip_q <= s_tdata[STRIP_W-1:0];
			sig_q   <= s_tdata[STRIP_W +: SIGNAL_W];
			noise_q <= s_tdata[STRIP_W+SIGNAL_W +: NOISE_W];
		end
		if (cmd.eval) begin
			hit_q  <= hit;
			near_q <= near;
			mag_q  <= sig_q[MAG_W-1:0];
			prod_q <= PROD_W'(strip_q) * PROD_W'(sig_q[MAG_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (cmd.start) begin
			open_q <= 1'b1;
		end else if (cmd.clear) begin
			open_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			last_q <= strip_q;
			esum_q <= ENERGY_W'(mag_q);
			wsum_q <= WEIGHT_W'(prod_q);
			size_q <= SIZE_W'(1);
		end else if (cmd.accum) begin
			last_q <= strip_q;
			esum_q <= e_add[ENERGY_W] ? '1 : e_add[ENERGY_W-1:0];
			wsum_q <= w_add[WEIGHT_W] ? '1 : w_add[WEIGHT_W-1:0];
			size_q <= (size_q == '1) ? size_q : size_q + 1'b1;
		end
	end

	scf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.div_load),
		.step     (cmd.div_step),
		.weight   (wsum_q),
		.energy   (esum_q),
		.quotient (quo),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rec_e_q     <= esum_q;
			rec_n_q     <= size_q;
			rec_valid_q <= 1'b1;
			rec_last_q  <= act_q == ACTION_END;
		end else if (cmd.rec_empty) begin
			rec_e_q     <= '0;
			rec_n_q     <= '0;
			rec_valid_q <= 1'b0;
			rec_last_q  <= 1'b1;
		end
	end

	assign cog = rec_valid_q ? quo : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			mvalid_q <= 1'b1;
		end else if (m_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mdata_q     <= OUT_DATA_W'({cog, rec_n_q, rec_e_q});
			mvalidbit_q <= rec_valid_q;
			mlast_q     <= rec_last_q;
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = mdata_q;
	assign m_tuser  = mvalidbit_q;
	assign m_tlast  = mlast_q;

	assign sts.is_end   = act_q == ACTION_END;
	assign sts.hit      = hit_q;
	assign sts.open     = open_q;
	assign sts.near     = near_q;
	assign sts.div_done = div_done;
	assign sts.out_free = !mvalid_q || m_tready;

endmodule

// File: hw/rtl/scf_ctrl.sv
module scf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  scf_pkg::sts_t  sts,
	output scf_pkg::cmd_t  cmd
);
	import scf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DECIDE,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_EVAL;
				end
				ST_EVAL: state_q <= ST_DECIDE;
				ST_DECIDE: begin
					if (sts.is_end) begin
						state_q <= sts.open ? ST_DIV : ST_OUT;
					end else if (sts.hit && sts.open && !sts.near) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (sts.div_done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = state_q == ST_IDLE;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.capture = s_tvalid;
			ST_EVAL: cmd.eval = 1'b1;
			ST_DECIDE: begin
				if (sts.is_end) begin
					cmd.div_load  = sts.open;
					cmd.rec_empty = !sts.open;
					cmd.clear     = 1'b1;
				end else if (sts.hit) begin
					if (!sts.open) begin
						cmd.start = 1'b1;
					end else if (sts.near) begin
						cmd.accum = 1'b1;
					end else begin
						cmd.div_load = 1'b1;
						cmd.start    = 1'b1;
					end
				end
			end
			ST_DIV: cmd.div_step = !sts.div_done;
			ST_OUT: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// File: hw/rtl/strip_cluster_finder_cog.sv
// sequence: each request is captured in idle, evaluated, then decided; a request with no
// record goes back to idle, one that closes a cluster runs the bit-serial divider and then
// hands its record to the output register, an empty end record goes straight to that register;
// s_tready is high only in idle, so a new request waits until the last one is through
// reset: arst_n asynchronous active low, clears the fsm, the open cluster and the output
// valid, and loads nsigma_multiplier with 6
module strip_cluster_finder_cog #(
	parameter int unsigned STRIP_COUNT = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration: nsigma_multiplier
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [scf_pkg::NSIG_W-1:0]      cfg_data,
	// input requests
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [9:0] strip_index, [25:10] strip_signal, [37:26] noise_sigma, [39:38] zero
	input  logic [scf_pkg::IN_DATA_W-1:0]   s_tdata,
	// [0] action, [1] strip_good
	input  logic [scf_pkg::IN_USER_W-1:0]   s_tuser,
	// cluster records
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [24:0] energy_total, [35:25] member_total, [53:36] cluster_cog, [55:54] zero
	output logic [scf_pkg::OUT_DATA_W-1:0]  m_tdata,
	// [0] cluster_valid
	output logic                            m_tuser,
	// event_last
	output logic                            m_tlast
);
	import scf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// the threshold register can always take a write
	assign cfg_ready = 1'b1;

	// fsm: idle, evaluate the sample, decide, run the divider, hand the record to the
	// output register (which frees the fsm while the record waits for m_tready)
	scf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: hit test, neighbor test, saturating sums and the cog divider
	scf_dp #(
		.STRIP_COUNT (STRIP_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
